// ----- hw/rtl/rgba_to_hsv_convert_assert.svh -----
// Assertion macros shared by the RGBA to HSV converter modules.
`ifndef RGBA_TO_HSV_CONVERT_ASSERT_SVH
`define RGBA_TO_HSV_CONVERT_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RTHSV_ASSERT_IMPLY(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("rgba_to_hsv_convert: assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define RTHSV_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("rgba_to_hsv_convert: assertion failed");

`endif

// ----- hw/rtl/rthsv_pkg.sv -----
// Types and constants shared by the RGBA to HSV converter modules.
`default_nettype none

package rthsv_pkg;

	// Field widths.
	localparam int CHAN_W    = 8;
	localparam int PROD_W    = 16;
	localparam int HUE_W     = 9;
	localparam int SAT_W     = 16;

	// Hue numerator is below 360 * 65025, saturation numerator is 65535 * delta.
	localparam int HUE_NUM_W = 25;
	localparam int SAT_NUM_W = 32;

	// One quotient bit per divider stage.
	localparam int DIV_STAGES     = SAT_W;
	localparam int HUE_DIV_STAGES = HUE_W;

	// Hue constants in degrees.
	localparam int HUE_SECTOR = 60;
	localparam int HUE_FULL   = 360;

	// One classified pixel, as queued between the front and back ends.
	typedef struct packed {
		logic [PROD_W-1:0]    bright;
		logic [PROD_W-1:0]    delta;
		logic [HUE_NUM_W-1:0] hue_num;
		logic                 gray;
	} item_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rthsv_front.sv -----
// Front end: alpha premultiply, max/min classification and hue numerator.
`default_nettype none

module rthsv_front (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                pix_valid,
	output logic                                     pix_ready,
	input  wire logic [rthsv_pkg::CHAN_W-1:0]        red_in,
	input  wire logic [rthsv_pkg::CHAN_W-1:0]        green_in,
	input  wire logic [rthsv_pkg::CHAN_W-1:0]        blue_in,
	input  wire logic [rthsv_pkg::CHAN_W-1:0]        alpha_in,
	input  wire logic                                q_full,
	output logic                                     push,
	output rthsv_pkg::item_t                         item
);

	localparam int PW = rthsv_pkg::PROD_W;
	localparam int NW = rthsv_pkg::HUE_NUM_W + 2;

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	logic            adv;
	logic            vld_s1, vld_s2, vld_s3;
	logic [PW-1:0]   red_s1, green_s1, blue_s1;
	logic [PW-1:0]   mx_s2, delta_s2;
	logic signed [PW:0] diff_s2;
	sector_t         sector_s2;
	rthsv_pkg::item_t item_s3;

	// Stage 2 combinational signals.
	logic [PW-1:0]      mx_c, mn_c;
	logic signed [PW:0] diff_c;
	sector_t            sector_c;

	// Stage 3 combinational signals.
	logic [rthsv_pkg::HUE_W-1:0]     base_c;
	logic [rthsv_pkg::HUE_NUM_W-1:0] base_prod_c;
	logic signed [NW-1:0]            scaled_diff_c, num_c;

	// The whole front moves as one; it holds while stage 3 holds a pixel and the queue is full.
	assign adv       = !vld_s3 || !q_full;
	assign pix_ready = adv;
	assign push      = vld_s3 && !q_full;
	assign item      = item_s3;

	// Valid bits of the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= pix_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Largest channel with red winning ties, then green; smallest channel.
	always_comb begin
		priority if (red_s1 >= green_s1 && red_s1 >= blue_s1) begin
			sector_c = SEC_RED;
			mx_c     = red_s1;
			diff_c   = $signed({1'b0, green_s1}) - $signed({1'b0, blue_s1});
		end else if (green_s1 >= blue_s1) begin
			sector_c = SEC_GREEN;
			mx_c     = green_s1;
			diff_c   = $signed({1'b0, blue_s1}) - $signed({1'b0, red_s1});
		end else begin
			sector_c = SEC_BLUE;
			mx_c     = blue_s1;
			diff_c   = $signed({1'b0, red_s1}) - $signed({1'b0, green_s1});
		end
		mn_c = red_s1;
		if (green_s1 < mn_c) mn_c = green_s1;
		if (blue_s1 < mn_c) mn_c = blue_s1;
	end

	// Hue numerator: sector offset times delta plus sixty times the difference.
	always_comb begin
		unique case (sector_s2)
			SEC_RED:   base_c = diff_s2 < 0 ? rthsv_pkg::HUE_W'(rthsv_pkg::HUE_FULL)
			                                : '0;
			SEC_GREEN: base_c = rthsv_pkg::HUE_W'(2 * rthsv_pkg::HUE_SECTOR);
			SEC_BLUE:  base_c = rthsv_pkg::HUE_W'(4 * rthsv_pkg::HUE_SECTOR);
			default:   base_c = '0;
		endcase
		base_prod_c   = rthsv_pkg::HUE_NUM_W'(base_c) * rthsv_pkg::HUE_NUM_W'(delta_s2);
		scaled_diff_c = NW'(diff_s2) * NW'(rthsv_pkg::HUE_SECTOR);
		num_c         = $signed({2'b00, base_prod_c}) + scaled_diff_c;
	end

	// Pipeline payload registers.
	always_ff @(posedge clk) begin
		if (adv) begin
			red_s1           <= PW'(red_in) * PW'(alpha_in);
			green_s1         <= PW'(green_in) * PW'(alpha_in);
			blue_s1          <= PW'(blue_in) * PW'(alpha_in);
			mx_s2            <= mx_c;
			delta_s2         <= mx_c - mn_c;
			diff_s2          <= diff_c;
			sector_s2        <= sector_c;
			item_s3.bright   <= mx_s2;
			item_s3.delta    <= delta_s2;
			item_s3.hue_num  <= num_c[rthsv_pkg::HUE_NUM_W-1:0];
			item_s3.gray     <= delta_s2 == '0;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/rthsv_fifo.sv -----
// Short queue of classified pixels between the front and back ends.
`default_nettype none

`include "rgba_to_hsv_convert_assert.svh"

module rthsv_fifo #(
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire rthsv_pkg::item_t wdata,
	output logic                  full,
	input  wire logic             pop,
	output rthsv_pkg::item_t      rdata,
	output logic                  not_empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	rthsv_pkg::item_t mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full      = count_q == CW'(DEPTH);
	assign not_empty = count_q != '0;
	assign rdata     = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q == AW'(DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q == AW'(DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// The front must never write into a full queue, the back never read an empty one.
	`RTHSV_ASSERT_IMPLY(a_push_room, push, count_q != CW'(DEPTH))
	`RTHSV_ASSERT_IMPLY(a_pop_data, pop, count_q != '0)
	`RTHSV_ASSERT_NEXT(a_push_fills, push && !pop, count_q != '0)

endmodule

`default_nettype wire

// ----- hw/rtl/rthsv_back.sv -----
// Back end: pipelined hue and saturation dividers and the output register.
`default_nettype none

`include "rgba_to_hsv_convert_assert.svh"

module rthsv_back (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire rthsv_pkg::item_t                    head,
	input  wire logic                                head_valid,
	output logic                                     pop,
	output logic                                     hsv_valid,
	input  wire logic                                hsv_ready,
	output logic [rthsv_pkg::HUE_W-1:0]              hue_deg,
	output logic [rthsv_pkg::SAT_W-1:0]              saturation_frac,
	output logic [rthsv_pkg::PROD_W-1:0]             brightness_raw
);

	localparam int NS  = rthsv_pkg::DIV_STAGES;
	localparam int NH  = rthsv_pkg::HUE_DIV_STAGES;
	localparam int PW  = rthsv_pkg::PROD_W;
	localparam int SW  = rthsv_pkg::SAT_W;
	localparam int HW  = rthsv_pkg::HUE_W;
	localparam int SNW = rthsv_pkg::SAT_NUM_W;
	localparam int HNW = rthsv_pkg::HUE_NUM_W;

	logic adv;

	// Per-stage pipeline registers, indexed by stage.
	logic           vld_s      [NS];
	logic [PW-1:0]  mx_s       [NS];
	logic           gray_s     [NS];
	logic [SW-1:0]  sat_quo_s  [NS];
	logic [HW-1:0]  hue_quo_s  [NS];
	logic [SNW-1:0] sat_rem_s  [NS-1];
	logic [HNW-1:0] hue_rem_s  [NH-1];
	logic [PW-1:0]  delta_s    [NH-1];

	// Output register.
	logic           hsv_valid_q;
	logic [HW-1:0]  hue_q;
	logic [SW-1:0]  sat_q;
	logic [PW-1:0]  bright_q;

	// All stages advance together unless a finished beat waits at the output.
	assign adv = !hsv_valid_q || hsv_ready;
	assign pop = adv && head_valid;

	for (genvar k = 0; k < NS; k++) begin : g_stage
		localparam int SB = NS - 1 - k;

		logic           vld_in;
		logic [PW-1:0]  mx_in;
		logic           gray_in;
		logic [SNW-1:0] sat_rem_in;
		logic [SW-1:0]  sat_quo_in;
		logic [HW-1:0]  hue_quo_in;
		logic [SNW-1:0] sat_den_sh;
		logic           sat_take;
		logic [SNW-1:0] sat_rem_nx;
		logic [SW-1:0]  sat_quo_nx;
		logic [HW-1:0]  hue_quo_nx;

		// Stage inputs: the queue head for the first stage, else the previous stage.
		if (k == 0) begin : g_first
			assign vld_in     = head_valid;
			assign mx_in      = head.bright;
			assign gray_in    = head.gray;
			assign sat_rem_in = {head.delta, {SW{1'b0}}} - SNW'(head.delta);
			assign sat_quo_in = '0;
			assign hue_quo_in = '0;
		end else begin : g_next
			assign vld_in     = vld_s[k-1];
			assign mx_in      = mx_s[k-1];
			assign gray_in    = gray_s[k-1];
			assign sat_rem_in = sat_rem_s[k-1];
			assign sat_quo_in = sat_quo_s[k-1];
			assign hue_quo_in = hue_quo_s[k-1];
		end

		// One restoring step of the saturation division.
		assign sat_den_sh = SNW'(mx_in) << SB;
		assign sat_take   = sat_rem_in >= sat_den_sh;
		assign sat_rem_nx = sat_take ? sat_rem_in - sat_den_sh : sat_rem_in;
		assign sat_quo_nx = sat_quo_in | (SW'(sat_take) << SB);

		// The hue quotient has fewer bits, so its steps run in the first stages only.
		if (k < NH) begin : g_hue
			localparam int HB = NH - 1 - k;

			logic [HNW-1:0] hue_rem_in;
			logic [PW-1:0]  delta_in;
			logic [HNW-1:0] hue_den_sh;
			logic           hue_take;
			logic [HNW-1:0] hue_rem_nx;

			if (k == 0) begin : g_hue_first
				assign hue_rem_in = head.hue_num;
				assign delta_in   = head.delta;
			end else begin : g_hue_next
				assign hue_rem_in = hue_rem_s[k-1];
				assign delta_in   = delta_s[k-1];
			end

			assign hue_den_sh = HNW'(delta_in) << HB;
			assign hue_take   = hue_rem_in >= hue_den_sh;
			assign hue_rem_nx = hue_take ? hue_rem_in - hue_den_sh : hue_rem_in;
			assign hue_quo_nx = hue_quo_in | (HW'(hue_take) << HB);

			if (k < NH - 1) begin : g_hue_keep
				always_ff @(posedge clk) begin
					if (adv) begin
						hue_rem_s[k] <= hue_rem_nx;
						delta_s[k]   <= delta_in;
					end
				end
			end
		end else begin : g_hue_done
			assign hue_quo_nx = hue_quo_in;
		end

		// Stage valid bit.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= vld_in;
			end
		end

		// Stage payload.
		always_ff @(posedge clk) begin
			if (adv) begin
				mx_s[k]      <= mx_in;
				gray_s[k]    <= gray_in;
				sat_quo_s[k] <= sat_quo_nx;
				hue_quo_s[k] <= hue_quo_nx;
			end
		end

		if (k < NS - 1) begin : g_sat_keep
			always_ff @(posedge clk) begin
				if (adv) begin
					sat_rem_s[k] <= sat_rem_nx;
				end
			end
		end
	end

	// Output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsv_valid_q <= 1'b0;
		end else if (adv) begin
			hsv_valid_q <= vld_s[NS-1];
		end
	end

	// Output payload; a gray pixel reports zero hue and saturation.
	always_ff @(posedge clk) begin
		if (adv) begin
			hue_q    <= gray_s[NS-1] ? '0 : hue_quo_s[NS-1];
			sat_q    <= gray_s[NS-1] ? '0 : sat_quo_s[NS-1];
			bright_q <= mx_s[NS-1];
		end
	end

	assign hsv_valid       = hsv_valid_q;
	assign hue_deg         = hue_q;
	assign saturation_frac = sat_q;
	assign brightness_raw  = bright_q;

	// Dividers only see in-range operands, and the hue stays below a full turn.
	`RTHSV_ASSERT_IMPLY(a_div_operands, pop, head.gray || (head.bright != '0 && head.delta <= head.bright))
	`RTHSV_ASSERT_IMPLY(a_hue_range, hsv_valid_q, hue_q < HW'(rthsv_pkg::HUE_FULL))

endmodule

`default_nettype wire

// ----- hw/rtl/rgba_to_hsv_convert.sv -----
// RGBA to HSV converter top level.
//
// Input channel pix_valid/pix_ready carries one 8-bit RGBA pixel per beat; the
// color channels are premultiplied by alpha. Output channel hsv_valid/hsv_ready
// carries one beat per pixel: hue_deg in whole degrees (0 to 359),
// saturation_frac (65535 means 1.0) and brightness_raw, the largest
// premultiplied channel. Results leave in input order.
// From an accepted pixel to its result on the output, a beat passes through
// three front stages (premultiply, classify, hue numerator), the queue
// and sixteen restoring divider stages plus the output register. The
// saturation quotient takes one bit per stage and sets the depth.
// Throughput is one pixel per cycle while hsv_ready stays high.
// When hsv_ready is low and a result waits, the back end holds; the queue of
// QUEUE_DEPTH entries then fills while the front keeps taking pixels, and
// pix_ready falls only once the queue is full and stage 3 holds a pixel.
// Reset clears all valid bits and the queue; no pixel is in flight afterward.
`default_nettype none

module rgba_to_hsv_convert #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                pix_valid,
	output logic                                     pix_ready,
	input  wire logic [rthsv_pkg::CHAN_W-1:0]        red_in,
	input  wire logic [rthsv_pkg::CHAN_W-1:0]        green_in,
	input  wire logic [rthsv_pkg::CHAN_W-1:0]        blue_in,
	input  wire logic [rthsv_pkg::CHAN_W-1:0]        alpha_in,
	output logic                                     hsv_valid,
	input  wire logic                                hsv_ready,
	output logic [rthsv_pkg::HUE_W-1:0]              hue_deg,
	output logic [rthsv_pkg::SAT_W-1:0]              saturation_frac,
	output logic [rthsv_pkg::PROD_W-1:0]             brightness_raw
);

	logic             push, q_full, pop, q_not_empty;
	rthsv_pkg::item_t push_item, head_item;

	rthsv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.alpha_in  (alpha_in),
		.q_full    (q_full),
		.push      (push),
		.item      (push_item)
	);

	rthsv_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     (push_item),
		.full      (q_full),
		.pop       (pop),
		.rdata     (head_item),
		.not_empty (q_not_empty)
	);

	rthsv_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (head_item),
		.head_valid      (q_not_empty),
		.pop             (pop),
		.hsv_valid       (hsv_valid),
		.hsv_ready       (hsv_ready),
		.hue_deg         (hue_deg),
		.saturation_frac (saturation_frac),
		.brightness_raw  (brightness_raw)
	);

endmodule

`default_nettype wire

// ----- sim/rgba_to_hsv_convert_tb.sv -----
// Self-checking testbench for the RGBA to HSV converter with random handshake idling.
`timescale 1ns / 1ps

module rgba_to_hsv_convert_tb;

	localparam int     CHAN_W     = rthsv_pkg::CHAN_W;
	localparam int     PROD_W     = rthsv_pkg::PROD_W;
	localparam int     HUE_W      = rthsv_pkg::HUE_W;
	localparam int     SAT_W      = rthsv_pkg::SAT_W;
	localparam int     HUE_SECTOR = rthsv_pkg::HUE_SECTOR;
	localparam int     HUE_FULL   = rthsv_pkg::HUE_FULL;
	localparam longint SAT_ONE    = 65535;
	localparam int     TAIL_CYC   = 60;

	typedef struct packed {
		logic [HUE_W-1:0]  hue;
		logic [SAT_W-1:0]  sat;
		logic [PROD_W-1:0] bright;
	} hsv_t;

	logic              clk;
	logic              arst_n;
	logic              pix_valid;
	logic              pix_ready;
	logic [CHAN_W-1:0] red_in;
	logic [CHAN_W-1:0] green_in;
	logic [CHAN_W-1:0] blue_in;
	logic [CHAN_W-1:0] alpha_in;
	logic              hsv_valid;
	logic              hsv_ready;
	logic [HUE_W-1:0]  hue_deg;
	logic [SAT_W-1:0]  saturation_frac;
	logic [PROD_W-1:0] brightness_raw;

	hsv_t hsv_due[$];
	hsv_t want;
	int   mismatches = 0;
	int   pixels_sent = 0;
	int   beats_checked = 0;
	int   stall_left = 0;
	bit   steady = 1'b0;

	rgba_to_hsv_convert dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.pix_valid       (pix_valid),
		.pix_ready       (pix_ready),
		.red_in          (red_in),
		.green_in        (green_in),
		.blue_in         (blue_in),
		.alpha_in        (alpha_in),
		.hsv_valid       (hsv_valid),
		.hsv_ready       (hsv_ready),
		.hue_deg         (hue_deg),
		.saturation_frac (saturation_frac),
		.brightness_raw  (brightness_raw)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the handshake locks up.
	initial begin
		#8_000_000;
		$display("Timeout with %0d HSV beats still outstanding", hsv_due.size());
		$display("Mismatches found");
		$finish;
	end

	// Idle length: mostly short, now and then a long stretch.
	function automatic int idle_length();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Expected HSV for one pixel, exact integer math on alpha-premultiplied channels.
	function automatic hsv_t hsv_of(input logic [CHAN_W-1:0] r8, g8, b8, a8);
		int   r, g, b, hi, lo, d, num;
		hsv_t res;
		r = int'(r8) * int'(a8);
		g = int'(g8) * int'(a8);
		b = int'(b8) * int'(a8);
		hi = r;
		if (g > hi) hi = g;
		if (b > hi) hi = b;
		lo = r;
		if (g < lo) lo = g;
		if (b < lo) lo = b;
		d = hi - lo;
		res.bright = PROD_W'(hi);
		res.hue = '0;
		res.sat = '0;
		if (d != 0) begin
			// Red wins ties for the largest channel, then green.
			if (hi == r) begin
				num = HUE_SECTOR * (g - b);
				if (num < 0) num += HUE_FULL * d;
			end else if (hi == g) begin
				num = 2 * HUE_SECTOR * d + HUE_SECTOR * (b - r);
			end else begin
				num = 4 * HUE_SECTOR * d + HUE_SECTOR * (r - g);
			end
			res.hue = HUE_W'(num / d);
			res.sat = SAT_W'((SAT_ONE * longint'(d)) / longint'(hi));
		end
		return res;
	endfunction

	// Send one pixel beat, with an optional idle gap first; returns at the accepting edge.
	task automatic send_pixel(input logic [CHAN_W-1:0] r, g, b, a);
		int gap;
		gap = 0;
		if (!steady && $urandom_range(0, 99) < 40) gap = idle_length();
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_valid <= 1'b1;
		red_in <= r;
		green_in <= g;
		blue_in <= b;
		alpha_in <= a;
		@(posedge clk);
		while (!pix_ready) @(posedge clk);
		hsv_due.push_back(hsv_of(r, g, b, a));
		pixels_sent++;
	endtask

	// Output side back-pressure: random stalls unless in a steady phase.
	initial begin
		hsv_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				hsv_ready <= 1'b0;
			end else if (!steady && $urandom_range(0, 99) < 15) begin
				stall_left = idle_length() - 1;
				hsv_ready <= 1'b0;
			end else begin
				hsv_ready <= 1'b1;
			end
		end
	end

	// Compare every accepted HSV beat against the oldest outstanding prediction.
	always @(posedge clk) begin
		if (arst_n && hsv_valid && hsv_ready) begin
			if (hsv_due.size() == 0) begin
				$display("%0t: unexpected HSV beat: hue %0d sat %0d bright %0d",
					$time, hue_deg, saturation_frac, brightness_raw);
				mismatches++;
			end else begin
				want = hsv_due.pop_front();
				beats_checked++;
				if (hue_deg !== want.hue) begin
					$display("%0t: hue_deg expected %0d actual %0d", $time, want.hue, hue_deg);
					mismatches++;
				end
				if (saturation_frac !== want.sat) begin
					$display("%0t: saturation_frac expected %0d actual %0d",
						$time, want.sat, saturation_frac);
					mismatches++;
				end
				if (brightness_raw !== want.bright) begin
					$display("%0t: brightness_raw expected %0d actual %0d",
						$time, want.bright, brightness_raw);
					mismatches++;
				end
			end
		end
	end

	// Corner pixels: black, white, zero alpha, primaries, channel ties, wrap near 360.
	task automatic test_corners();
		send_pixel(8'd0,   8'd0,   8'd0,   8'd0);
		send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0,   8'd0,   8'd0);
		send_pixel(8'd0,   8'd255, 8'd255, 8'd0);
		send_pixel(8'd200, 8'd100, 8'd50,  8'd1);
		send_pixel(8'd255, 8'd0,   8'd0,   8'd255);
		send_pixel(8'd0,   8'd255, 8'd0,   8'd255);
		send_pixel(8'd0,   8'd0,   8'd255, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd0,   8'd255);
		send_pixel(8'd0,   8'd255, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0,   8'd255, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd254, 8'd255);
		send_pixel(8'd255, 8'd0,   8'd1,   8'd255);
		send_pixel(8'd255, 8'd1,   8'd0,   8'd255);
		send_pixel(8'd1,   8'd0,   8'd0,   8'd255);
		send_pixel(8'd255, 8'd254, 8'd254, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128, 8'd200);
		send_pixel(8'd0,   8'd0,   8'd1,   8'd1);
		send_pixel(8'd10,  8'd200, 8'd30,  8'd128);
		send_pixel(8'd90,  8'd255, 8'd90,  8'd255);
		send_pixel(8'd255, 8'd128, 8'd0,   8'd170);
		send_pixel(8'd0,   8'd1,   8'd255, 8'd255);
	endtask

	// Fully random pixels.
	task automatic test_random_pixels(input int count);
		for (int i = 0; i < count; i++)
			send_pixel(CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom),
				CHAN_W'($urandom));
	endtask

	// Pixels built per hue sector, with ties and grays mixed in.
	task automatic test_hue_sectors(input int count);
		logic [CHAN_W-1:0] hi_c, mid_c, lo_c, a;
		int                tie;
		for (int i = 0; i < count; i++) begin
			hi_c = CHAN_W'($urandom_range(1, 255));
			mid_c = CHAN_W'($urandom_range(0, hi_c));
			lo_c = CHAN_W'($urandom_range(0, mid_c));
			tie = $urandom_range(0, 9);
			if (tie < 2) mid_c = hi_c;
			else if (tie == 2) lo_c = mid_c;
			else if (tie == 3) begin
				mid_c = hi_c;
				lo_c = hi_c;
			end
			a = ($urandom_range(0, 1) == 0) ? CHAN_W'(255) : CHAN_W'($urandom_range(1, 255));
			case ($urandom_range(0, 5))
				0: send_pixel(hi_c, mid_c, lo_c, a);
				1: send_pixel(hi_c, lo_c, mid_c, a);
				2: send_pixel(mid_c, hi_c, lo_c, a);
				3: send_pixel(lo_c, hi_c, mid_c, a);
				4: send_pixel(mid_c, lo_c, hi_c, a);
				default: send_pixel(lo_c, mid_c, hi_c, a);
			endcase
		end
	endtask

	// Near-gray pixels and extreme alpha values.
	task automatic test_gray_and_alpha(input int count);
		logic [CHAN_W-1:0] base, a;
		int                spread;
		for (int i = 0; i < count; i++) begin
			base = CHAN_W'($urandom);
			case ($urandom_range(0, 5))
				0: a = CHAN_W'(0);
				1: a = CHAN_W'(1);
				2: a = CHAN_W'(2);
				3: a = CHAN_W'(254);
				4: a = CHAN_W'(255);
				default: a = CHAN_W'($urandom);
			endcase
			if ($urandom_range(0, 9) < 4) begin
				send_pixel(base, base, base, a);
			end else begin
				spread = $urandom_range(1, 3);
				send_pixel(CHAN_W'(base + $urandom_range(0, spread)),
					CHAN_W'(base + $urandom_range(0, spread)),
					CHAN_W'(base + $urandom_range(0, spread)), a);
			end
		end
	endtask

	// Full-rate streaming with no idling on either side.
	task automatic test_back_to_back(input int count);
		steady = 1'b1;
		test_random_pixels(count);
		steady = 1'b0;
	endtask

	// Test sequence.
	initial begin
		arst_n <= 1'b0;
		pix_valid <= 1'b0;
		red_in <= '0;
		green_in <= '0;
		blue_in <= '0;
		alpha_in <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corners();
		test_random_pixels(500);
		test_hue_sectors(500);
		test_back_to_back(300);
		test_gray_and_alpha(250);
		test_random_pixels(200);
		pix_valid <= 1'b0;

		// Drain, then watch a while longer for stray beats.
		while (hsv_due.size() != 0) @(posedge clk);
		repeat (TAIL_CYC) @(posedge clk);

		$display("Sent %0d pixels and checked %0d HSV beats: corners, hue sectors, ties,",
			pixels_sent, beats_checked);
		$display("near-gray and alpha extremes, with random stalls and a full-rate stretch.");
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
